>>> src/rsam_pkg.sv
// ----------------------------------------------------------------------------
// rsam_pkg
// Shared types and codes of the roulette selection / adaptive mutation engine.
// ----------------------------------------------------------------------------
package rsam_pkg;

   localparam int FIT_W  = 16;
   localparam int RATE_W = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_ADD    = 2'd1;
   localparam logic [1:0] FUNC_SELECT = 2'd2;
   localparam logic [1:0] FUNC_STATS  = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ADAPT_EN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_RATE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RATE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_EARLY_GEN = 3'd5;

   localparam logic [RATE_W-1:0] ONE_Q16 = 17'd65536;

   typedef struct packed {
      logic [1:0]       func;
      logic [FIT_W-1:0] fitness;
      logic [15:0]      random_fraction;
      logic [15:0]      generation;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [3:0]        selected_index;
      logic [19:0]       total_fitness;
      logic [FIT_W-1:0]  best_fitness;
      logic [FIT_W-1:0]  average_fitness;
      logic [RATE_W-1:0] diversity_ratio;
      logic [RATE_W-1:0] mutation_rate;
      logic [4:0]        population_count;
   } rsp_payload_type;

endpackage

>>> src/rsam_chan_if.sv
// ----------------------------------------------------------------------------
// rsam_chan_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface rsam_chan_if #(
   parameter type data_type = logic
);
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/roulette_select_adaptive_mutation.sv
// ----------------------------------------------------------------------------
// roulette_select_adaptive_mutation
// Fitness store with roulette-wheel selection, statistics and adaptive
// mutation rate.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | content
//  req_chan | in  | valid/ready        | func, fitness, random_fraction, generation
//  rsp_chan | out | valid/ready        | status, index, statistics, count
//  csr_*    | in  | write enable only  | six registers by index
//
//  clear, add and an empty select go straight to the done state; select
//  makes two walks over the single-read-port fitness RAM; statistics use
//  the bit-serial divider (up to twice) and root, both RW bits wide
//  (RW = 37 for MAX_POP 16).
//  one item is in work at a time; a finished item waits in the output
//  register while the next one is accepted.
//  synchronous reset clears the count and loads the register defaults.
// ----------------------------------------------------------------------------
module roulette_select_adaptive_mutation #(
   parameter int MAX_POP = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   rsam_chan_if.sink                           req_chan,
   rsam_chan_if.source                         rsp_chan,
   input  logic                                csr_write_en,
   input  logic [rsam_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rsam_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rsam_pkg::*;

   localparam int CW  = $clog2(MAX_POP + 1);
   localparam int IW  = $clog2(MAX_POP);
   localparam int TW  = FIT_W + CW;
   localparam int SW  = 2 * FIT_W + CW;
   localparam int NVW = SW + CW;
   localparam int RW  = (NVW + 33) / 2;
   localparam int QW  = FIT_W + CW;

   typedef enum logic [3:0] {
      S_IDLE, S_SUM, S_SLICE, S_SCAN, S_AVG, S_VAR1, S_VAR2,
      S_ROOT, S_RDIV, S_RATE1, S_RATE2, S_DONE
   } state_type;

   state_type         state_ff;
   logic              adapt_en_ff;
   logic [RATE_W-1:0] base_rate_ff, min_rate_ff, max_rate_ff, floor_ff;
   logic [15:0]       early_gen_ff;

   logic [CW-1:0]     cnt_ff, idx_ff, cons_ff;
   logic              pend_ff;
   logic [1:0]        func_ff;
   logic [15:0]       frac_ff, gen_ff;
   logic [TW-1:0]     tot_ff, run_ff, slice_ff;
   logic [SW-1:0]     s2_ff;
   logic [FIT_W-1:0]  best_ff;
   logic [NVW-1:0]    nvar_ff, tt_ff, var_ff;
   logic signed [35:0] prod_ff;
   logic [RW-1:0]     div_a_ff;
   logic [QW-1:0]     div_b_ff;
   logic              div_start_ff, sqrt_start_ff;
   rsp_payload_type   res_ff, out_ff;
   logic              out_vld_ff;

   logic              accept, issue;
   logic              ram_we;
   logic              load_out;
   rsp_payload_type   res_init, res_out;
   logic [FIT_W-1:0]  rd_data;
   logic [2*FIT_W-1:0] sq;
   logic [TW-1:0]     run_in;
   logic [TW+15:0]    slice_prod;
   logic              div_done, sqrt_done;
   logic [RW-1:0]     quotient, root;
   logic [17:0]       need;
   logic signed [17:0] diff;
   logic signed [35:0] rate_w;
   logic [RATE_W-1:0] rate_in;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign ram_we = accept && req_chan.data.func == FUNC_ADD && cnt_ff != CW'(MAX_POP);
   assign issue  = (state_ff == S_SUM || state_ff == S_SCAN) && idx_ff < cnt_ff;
   assign load_out = (state_ff == S_DONE) && (!out_vld_ff || rsp_chan.ready);
   assign sq     = rd_data * rd_data;
   assign run_in = run_ff + TW'(rd_data);
   assign slice_prod = (TW+16)'(tot_ff) * (TW+16)'(frac_ff);
   assign need   = 18'd65536 - 18'(res_ff.diversity_ratio);
   assign diff   = $signed({1'b0, max_rate_ff}) - $signed({1'b0, min_rate_ff});
   assign rate_w = $signed({19'b0, min_rate_ff}) + (prod_ff >>> 16);
   assign rate_in = (gen_ff < early_gen_ff && rate_w[16:0] < floor_ff) ? floor_ff
                                                                        : rate_w[16:0];

   // result of a newly accepted item before any walk
   always_comb begin
      res_init = '0;
      if (req_chan.data.func == FUNC_ADD && cnt_ff == CW'(MAX_POP)) begin
         res_init.status = STATUS_FULL;
      end else if (req_chan.data.func == FUNC_SELECT && cnt_ff == '0) begin
         res_init.status = STATUS_EMPTY;
      end
   end

   always_comb begin
      res_out = res_ff;
      res_out.population_count = 5'(cnt_ff);
   end

   rsam_ram #(.WIDTH(FIT_W), .DEPTH(MAX_POP)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cnt_ff[IW-1:0]),
      .wr_data (req_chan.data.fitness),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (rd_data)
   );

   rsam_div #(.DW(RW), .VW(QW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_a_ff),
      .divisor  (div_b_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   rsam_sqrt #(.RW(RW)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start_ff),
      .radicand ((2*RW)'({var_ff, 32'b0})),
      .done     (sqrt_done),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         pend_ff       <= 1'b0;
         out_vld_ff    <= 1'b0;
         div_start_ff  <= 1'b0;
         sqrt_start_ff <= 1'b0;
         adapt_en_ff   <= 1'b1;
         base_rate_ff  <= 17'd6554;
         min_rate_ff   <= 17'd3277;
         max_rate_ff   <= 17'd19661;
         floor_ff      <= 17'd9830;
         early_gen_ff  <= 16'd10;
      end else begin
         div_start_ff  <= (state_ff == S_SUM && !pend_ff && !issue && func_ff != FUNC_SELECT)
                          || (state_ff == S_ROOT && sqrt_done);
         sqrt_start_ff <= (state_ff == S_VAR2);
         pend_ff       <= issue;
         if (issue) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (load_out) begin
            out_vld_ff <= 1'b1;
         end else if (out_vld_ff && rsp_chan.ready) begin
            out_vld_ff <= 1'b0;
         end

         if (csr_write_en) begin
            case (csr_index)
               CSR_ADAPT_EN:  adapt_en_ff  <= csr_wdata[0];
               CSR_BASE_RATE: base_rate_ff <= csr_wdata;
               CSR_MIN_RATE:  min_rate_ff  <= csr_wdata;
               CSR_MAX_RATE:  max_rate_ff  <= csr_wdata;
               CSR_FLOOR:     floor_ff     <= csr_wdata;
               CSR_EARLY_GEN: early_gen_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  res_ff  <= res_init;
                  func_ff <= req_chan.data.func;
                  frac_ff <= req_chan.data.random_fraction;
                  gen_ff  <= req_chan.data.generation;
                  idx_ff  <= '0;
                  tot_ff  <= '0;
                  s2_ff   <= '0;
                  best_ff <= '0;
                  case (req_chan.data.func)
                     FUNC_CLEAR: begin
                        cnt_ff   <= '0;
                        state_ff <= S_DONE;
                     end
                     FUNC_ADD: begin
                        if (cnt_ff != CW'(MAX_POP)) begin
                           cnt_ff <= cnt_ff + 1'b1;
                        end
                        state_ff <= S_DONE;
                     end
                     FUNC_SELECT: state_ff <= (cnt_ff == '0) ? S_DONE : S_SUM;
                     default: state_ff <= (cnt_ff == '0) ? S_RATE1 : S_SUM;
                  endcase
               end
            end
            S_SUM: begin
               if (pend_ff) begin
                  tot_ff <= tot_ff + TW'(rd_data);
                  s2_ff  <= s2_ff + SW'(sq);
                  if (rd_data > best_ff) begin
                     best_ff <= rd_data;
                  end
               end else if (!issue) begin
                  if (func_ff == FUNC_SELECT) begin
                     state_ff <= S_SLICE;
                  end else begin
                     div_a_ff     <= RW'(tot_ff);
                     div_b_ff     <= QW'(cnt_ff);
                     state_ff     <= S_AVG;
                  end
               end
            end
            S_SLICE: begin
               slice_ff <= slice_prod[TW+15:16];
               idx_ff   <= '0;
               cons_ff  <= '0;
               run_ff   <= '0;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (pend_ff) begin
                  run_ff  <= run_in;
                  cons_ff <= cons_ff + 1'b1;
                  // first entry whose running sum reaches the slice, else the last entry
                  if (run_in >= slice_ff || cons_ff == cnt_ff - 1'b1) begin
                     res_ff.selected_index <= 4'(cons_ff);
                     state_ff <= S_DONE;
                  end
               end
            end
            S_AVG: begin
               if (div_done) begin
                  res_ff.average_fitness <= quotient[FIT_W-1:0];
                  res_ff.total_fitness   <= 20'(tot_ff);
                  res_ff.best_fitness    <= best_ff;
                  if (cnt_ff < CW'(2)) begin
                     state_ff <= S_RATE1;
                  end else if (best_ff == '0) begin
                     res_ff.diversity_ratio <= ONE_Q16;
                     state_ff <= S_RATE1;
                  end else begin
                     state_ff <= S_VAR1;
                  end
               end
            end
            S_VAR1: begin
               nvar_ff  <= NVW'(s2_ff) * NVW'(cnt_ff);
               tt_ff    <= NVW'(tot_ff) * NVW'(tot_ff);
               state_ff <= S_VAR2;
            end
            S_VAR2: begin
               var_ff        <= (nvar_ff > tt_ff) ? nvar_ff - tt_ff : '0;
               state_ff      <= S_ROOT;
            end
            S_ROOT: begin
               if (sqrt_done) begin
                  // diversity = floor(isqrt(var * 2^32) / (n * best))
                  div_a_ff     <= root;
                  div_b_ff     <= QW'(cnt_ff) * QW'(best_ff);
                  state_ff     <= S_RDIV;
               end
            end
            S_RDIV: begin
               if (div_done) begin
                  res_ff.diversity_ratio <= (quotient > RW'(ONE_Q16)) ? ONE_Q16
                                                                      : quotient[16:0];
                  state_ff <= S_RATE1;
               end
            end
            S_RATE1: begin
               if (!adapt_en_ff || best_ff == '0) begin
                  res_ff.mutation_rate <= base_rate_ff;
                  state_ff <= S_DONE;
               end else begin
                  prod_ff  <= 36'(diff) * 36'($signed(need));
                  state_ff <= S_RATE2;
               end
            end
            S_RATE2: begin
               res_ff.mutation_rate <= rate_in;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (load_out) begin
                  out_ff   <= res_out;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid = out_vld_ff;
   assign rsp_chan.data  = out_ff;
endmodule

>>> src/rsam_ram.sv
// ----------------------------------------------------------------------------
// rsam_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsam_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> src/rsam_div.sv
// ----------------------------------------------------------------------------
// rsam_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsam_div #(
   parameter int DW = 32,
   parameter int VW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);
   localparam int CNT_W = $clog2(DW + 1);

   logic [VW-1:0]    rem_ff;
   logic [DW-1:0]    quo_ff;
   logic [VW-1:0]    dsr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [VW:0]      shifted;
   logic             ge;

   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign ge      = shifted >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DW);
            rem_ff  <= '0;
            quo_ff  <= dividend;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= ge ? VW'(shifted - {1'b0, dsr_ff}) : shifted[VW-1:0];
            quo_ff <= {quo_ff[DW-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

>>> src/rsam_sqrt.sv
// ----------------------------------------------------------------------------
// rsam_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rsam_sqrt #(
   parameter int RW = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [2*RW-1:0] radicand,
   output logic            done,
   output logic [RW-1:0]   root
);
   localparam int CNT_W = $clog2(RW + 1);

   logic [2*RW-1:0]  rad_ff;
   logic [RW:0]      rem_ff;
   logic [RW-1:0]    root_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [RW+2:0]    rem_sh;
   logic [RW+2:0]    trial;
   logic             ge;

   assign rem_sh = {rem_ff, rad_ff[2*RW-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign ge     = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(RW);
            rad_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            rem_ff  <= ge ? (RW+1)'(rem_sh - trial) : rem_sh[RW:0];
            root_ff <= {root_ff[RW-2:0], ge};
            rad_ff  <= {rad_ff[2*RW-3:0], 2'b00};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
